// ===== hw/rtl/kic_pkg.sv =====
// Shared constants, codes and control types of the keypad calculator.
package kic_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int VALUE_W        = 32;
  localparam int REQ_W          = 3;
  localparam int DIGIT_W        = 4;
  localparam int OPC_W          = 3;
  localparam int ACT_W          = 2;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  typedef enum logic [REQ_W-1:0] {
    REQ_DIGIT       = 3'd0,
    REQ_OPERATOR    = 3'd1,
    REQ_EQUALS      = 3'd2,
    REQ_CLEAR_ENTRY = 3'd3,
    REQ_ALL_CLEAR   = 3'd4
  } req_t;

  typedef enum logic [OPC_W-1:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_REM  = 3'd5
  } op_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE  = 2'd0,
    ACT_SHOW  = 2'd1,
    ACT_BLANK = 2'd2
  } act_t;

  // controller -> datapath
  typedef struct packed {
    logic key_load;
    logic calc_start;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_calc;
    logic calc_done;
  } stat_t;

endpackage

// ===== hw/rtl/kic_key_if.sv =====
// Key event channel: valid/ready handshake with the key payload.
interface kic_key_if;
  import kic_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [DIGIT_W-1:0] digit;
  logic [OPC_W-1:0]   operator_code;

  modport source (output valid, output req_type, output digit, output operator_code,
                  input ready);
  modport sink   (input valid, input req_type, input digit, input operator_code,
                  output ready);
endinterface

// ===== hw/rtl/kic_result_if.sv =====
// Result channel: valid/ready handshake with the result payload.
interface kic_result_if;
  import kic_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [ACT_W-1:0]          display_action;
  logic                      divide_error;

  modport source (output valid, output value, output display_action, output divide_error,
                  input ready);
  modport sink   (input valid, input value, input display_action, input divide_error,
                  output ready);
endinterface

// ===== hw/rtl/kic_muldiv.sv =====
// Iterative unit: shift-add multiply or signed restoring divide, one bit per cycle.
module kic_muldiv #(
  parameter int DATA_WIDTH = kic_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  op_mul,
  input  logic                  op_rem,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] res
);
  import kic_pkg::*;

  localparam int CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

  logic                  busy;
  logic [CNT_W-1:0]      cnt;
  logic                  is_mul;
  logic                  want_rem;
  logic                  neg_q;
  logic                  neg_r;
  logic [DATA_WIDTH-1:0] sh;   // multiplicand / dividend-quotient shift reg
  logic [DATA_WIDTH-1:0] opb;  // multiplier / divisor magnitude
  logic [DATA_WIDTH-1:0] acc;  // product / partial remainder

  logic [DATA_WIDTH-1:0] mag_a;
  logic [DATA_WIDTH-1:0] mag_b;
  logic [DATA_WIDTH:0]   shifted;
  logic [DATA_WIDTH:0]   trial;

  assign mag_a   = a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
  assign mag_b   = b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
  assign shifted = {acc, sh[DATA_WIDTH-1]};
  assign trial   = shifted - {1'b0, opb};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        is_mul   <= op_mul;
        want_rem <= op_rem;
        acc      <= '0;
        if (op_mul) begin
          sh  <= a;
          opb <= b;
        end else begin
          sh    <= mag_a;
          opb   <= mag_b;
          neg_q <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
          neg_r <= a[DATA_WIDTH-1];
        end
      end else if (busy) begin
        if (is_mul) begin
          if (opb[0]) begin
            acc <= acc + sh;
          end
          sh  <= sh << 1;
          opb <= opb >> 1;
        end else begin
          // remainder stays below the divisor, so it fits in DATA_WIDTH bits
          if (!trial[DATA_WIDTH]) begin
            acc <= trial[DATA_WIDTH-1:0];
          end else begin
            acc <= shifted[DATA_WIDTH-1:0];
          end
          sh <= {sh[DATA_WIDTH-2:0], ~trial[DATA_WIDTH]};
        end
        cnt <= cnt + 1'b1;
        if (cnt == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (is_mul) begin
      res = acc;
    end else if (want_rem) begin
      res = neg_r ? (~acc + 1'b1) : acc;
    end else begin
      res = neg_q ? (~sh + 1'b1) : sh;
    end
  end

endmodule

// ===== hw/rtl/kic_dp.sv =====
// Datapath: operand, operator and result registers, key decode and output register.
module kic_dp #(
  parameter int DATA_WIDTH = kic_pkg::DATA_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  kic_pkg::cmd_t                      cmd,
  output kic_pkg::stat_t                     stat,
  input  logic [kic_pkg::REQ_W-1:0]          req_type,
  input  logic [kic_pkg::DIGIT_W-1:0]        digit,
  input  logic [kic_pkg::OPC_W-1:0]          operator_code,
  output logic signed [kic_pkg::VALUE_W-1:0] value,
  output logic [kic_pkg::ACT_W-1:0]          display_action,
  output logic                               divide_error
);
  import kic_pkg::*;

  logic [DATA_WIDTH-1:0] first_operand;
  logic [DATA_WIDTH-1:0] second_operand;
  logic [DATA_WIDTH-1:0] last_result;
  op_t                   pending_operator;
  logic                  operator_seen;
  act_t                  act;
  logic                  err;

  logic [DATA_WIDTH-1:0] entry;
  logic [DATA_WIDTH-1:0] entry_next;
  logic                  div_zero;
  logic [DATA_WIDTH-1:0] calc_res;
  logic                  need_calc;
  logic                  calc_done;

  assign entry      = operator_seen ? second_operand : first_operand;
  // x * 10 + digit
  assign entry_next = (entry << 3) + (entry << 1) + DATA_WIDTH'(digit);
  assign div_zero   = (second_operand == '0);
  assign stat       = {need_calc, calc_done};

  always_comb begin
    need_calc = 1'b0;
    if (req_t'(req_type) == REQ_EQUALS) begin
      case (pending_operator)
        OP_MUL:         need_calc = 1'b1;
        OP_DIV, OP_REM: need_calc = !div_zero;
        default:        need_calc = 1'b0;
      endcase
    end
  end

  kic_muldiv #(.DATA_WIDTH(DATA_WIDTH)) u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.calc_start),
    .op_mul (pending_operator == OP_MUL),
    .op_rem (pending_operator == OP_REM),
    .a      (first_operand),
    .b      (second_operand),
    .done   (calc_done),
    .res    (calc_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      first_operand    <= '0;
      second_operand   <= '0;
      last_result      <= '0;
      pending_operator <= OP_NONE;
      operator_seen    <= 1'b0;
      act              <= ACT_NONE;
      err              <= 1'b0;
    end else if (calc_done) begin
      last_result <= calc_res;
    end else if (cmd.key_load) begin
      act <= ACT_NONE;
      err <= 1'b0;
      case (req_t'(req_type))
        REQ_DIGIT: begin
          if (digit <= DIGIT_MAX) begin
            if (operator_seen) begin
              second_operand <= entry_next;
            end else begin
              first_operand <= entry_next;
            end
          end
        end
        REQ_OPERATOR: begin
          if (operator_code inside {[OP_ADD:OP_REM]}) begin
            pending_operator <= op_t'(operator_code);
            operator_seen    <= 1'b1;
          end
        end
        REQ_EQUALS: begin
          act <= ACT_SHOW;
          case (pending_operator)
            OP_ADD:         last_result <= first_operand + second_operand;
            OP_SUB:         last_result <= first_operand - second_operand;
            OP_DIV, OP_REM: err <= div_zero;
            default:        ;
          endcase
        end
        REQ_CLEAR_ENTRY: begin
          first_operand    <= '0;
          second_operand   <= '0;
          pending_operator <= OP_NONE;
          operator_seen    <= 1'b0;
          act              <= ACT_SHOW;
        end
        REQ_ALL_CLEAR: begin
          first_operand    <= '0;
          second_operand   <= '0;
          last_result      <= '0;
          pending_operator <= OP_NONE;
          operator_seen    <= 1'b0;
          act              <= ACT_BLANK;
        end
        default: ;
      endcase
    end
  end

  // output register; the size cast sign-extends or truncates to the port width
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value          <= VALUE_W'($signed(last_result));
      display_action <= act;
      divide_error   <= err;
    end
  end

endmodule

// ===== hw/rtl/kic_ctrl.sv =====
// Controller: sequences key decode, the iterative unit and the result register.
module kic_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           key_valid,
  output logic           key_ready,
  output logic           res_valid,
  input  logic           res_ready,
  input  kic_pkg::stat_t stat,
  output kic_pkg::cmd_t  cmd
);
  import kic_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  state_t state;
  logic   out_free;
  logic   key_load;
  logic   calc_start;
  logic   out_load;

  assign key_ready  = (state == ST_IDLE);
  assign out_free   = !res_valid || res_ready;
  assign key_load   = key_ready && key_valid;
  assign calc_start = key_load && stat.need_calc;
  assign out_load   = (state == ST_EMIT) && out_free;
  assign cmd        = {key_load, calc_start, out_load};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      if (out_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (key_load) begin
            state <= stat.need_calc ? ST_CALC : ST_EMIT;
          end
        end
        ST_CALC: begin
          if (stat.calc_done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/keypad_integer_calculator_top.sv =====
// Top level of the keypad integer calculator: controller, datapath and checks.
//
// One key event in, one result item out. Keys are taken one at a time. Digits,
// operators, clears, and equals with add, subtract, no operator or a zero
// divisor pass from acceptance through the emit state back to idle; equals
// with multiply, divide or remainder first waits in the calc state for the
// shared multiply/divide unit, which resolves one bit per cycle. The
// result sits in an output register, so a key can be accepted while the
// previous result is still waiting to be taken. Results are DATA_WIDTH-bit
// two's complement, sign-extended or truncated to 32 bits on the value port.
module keypad_integer_calculator_top #(
  parameter int DATA_WIDTH = kic_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  kic_key_if.sink      key,
  kic_result_if.source result
);
  import kic_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  kic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key.valid),
    .key_ready (key.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  kic_dp #(.DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_type       (key.req_type),
    .digit          (key.digit),
    .operator_code  (key.operator_code),
    .value          (result.value),
    .display_action (result.display_action),
    .divide_error   (result.divide_error)
  );

  // one key in flight at a time
  assert property (@(posedge clk) disable iff (rst)
    key.valid && key.ready |=> !key.ready)
    else $error("key accepted while previous item still in work");

  // the iterative unit never finishes right after being started
  assert property (@(posedge clk) disable iff (rst)
    cmd.calc_start |=> !stat.calc_done)
    else $error("multiply/divide finished too early");

  // a divide error only comes with an equals, which shows the value
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.divide_error |-> result.display_action == ACT_SHOW)
    else $error("divide error on a non-equals item");

  // all clear blanks the display with a zero result
  assert property (@(posedge clk) disable iff (rst)
    result.valid && result.display_action == ACT_BLANK |-> result.value == '0)
    else $error("all clear left a nonzero result");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the keypad integer calculator: key table, then random key sequences.
module tb_top;
  import kic_pkg::*;

  localparam int DW           = DATA_WIDTH_DEF;
  localparam int SETTLE       = 2 * (DW + 3);
  localparam int HOLD_LEN     = 300;
  localparam int CYCLE_CAP    = 400000;
  localparam int PHASE_KEYS   = 335;
  localparam int DECIMAL_BASE = 10;
  localparam int MAX_REPORTS  = 40;

  // keys the block has to ignore
  localparam logic [REQ_W-1:0]   REQ_BAD_LO = 3'd5;
  localparam logic [REQ_W-1:0]   REQ_BAD_HI = 3'd7;
  localparam logic [OPC_W-1:0]   OPC_BAD    = 3'd7;
  localparam logic [DIGIT_W-1:0] DIGIT_BAD  = 4'd15;

  // decimal key strings that land on the signed extremes and on minus one
  localparam longint unsigned MIN_DEC     = 64'd2147483648;
  localparam longint unsigned NEG_ONE_DEC = 64'd4294967295;
  localparam longint unsigned MAX_DEC     = 64'd2147483647;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    act_t                      act;
    logic                      err;
  } readout_t;

  typedef struct {
    logic [REQ_W-1:0]   req;
    logic [DIGIT_W-1:0] dig;
    logic [OPC_W-1:0]   opc;
    bit                 fixed;
    readout_t           want;
  } key_row_t;

  localparam readout_t ZERO_QUIET = '{32'sd0, ACT_NONE, 1'b0};
  localparam readout_t ZERO_SHOWN = '{32'sd0, ACT_SHOW, 1'b0};
  localparam readout_t ZERO_DIV0  = '{32'sd0, ACT_SHOW, 1'b1};
  localparam readout_t ZERO_BLANK = '{32'sd0, ACT_BLANK, 1'b0};
  localparam readout_t SUM_SHOWN  = '{32'sd106, ACT_SHOW, 1'b0};

  localparam int N_INTRO = 27;
  key_row_t intro_keys [N_INTRO] = '{
    '{REQ_EQUALS,      4'd0,      OP_NONE, 1'b1, ZERO_SHOWN},
    '{REQ_DIGIT,       4'd9,      OP_NONE, 1'b1, ZERO_QUIET},
    '{REQ_DIGIT,       4'd9,      OP_NONE, 1'b1, ZERO_QUIET},
    '{REQ_DIGIT,       DIGIT_BAD, OP_NONE, 1'b1, ZERO_QUIET},
    '{REQ_OPERATOR,    4'd0,      OP_NONE, 1'b1, ZERO_QUIET},
    '{REQ_OPERATOR,    4'd0,      OPC_BAD, 1'b1, ZERO_QUIET},
    '{REQ_EQUALS,      4'd0,      OP_NONE, 1'b1, ZERO_SHOWN},
    '{REQ_OPERATOR,    4'd0,      OP_DIV,  1'b1, ZERO_QUIET},
    '{REQ_EQUALS,      4'd0,      OP_NONE, 1'b1, ZERO_DIV0},
    '{REQ_OPERATOR,    4'd0,      OP_REM,  1'b1, ZERO_QUIET},
    '{REQ_EQUALS,      4'd0,      OP_NONE, 1'b1, ZERO_DIV0},
    '{REQ_DIGIT,       4'd7,      OP_NONE, 1'b1, ZERO_QUIET},
    '{REQ_OPERATOR,    4'd0,      OP_ADD,  1'b1, ZERO_QUIET},
    '{REQ_EQUALS,      4'd0,      OP_NONE, 1'b1, SUM_SHOWN},
    '{REQ_EQUALS,      4'd0,      OP_NONE, 1'b1, SUM_SHOWN},
    '{REQ_OPERATOR,    4'd0,      OP_SUB,  1'b0, ZERO_QUIET},
    '{REQ_EQUALS,      4'd0,      OP_NONE, 1'b0, ZERO_QUIET},
    '{REQ_OPERATOR,    4'd0,      OP_MUL,  1'b0, ZERO_QUIET},
    '{REQ_EQUALS,      4'd0,      OP_NONE, 1'b0, ZERO_QUIET},
    '{REQ_OPERATOR,    4'd0,      OP_DIV,  1'b0, ZERO_QUIET},
    '{REQ_EQUALS,      4'd0,      OP_NONE, 1'b0, ZERO_QUIET},
    '{REQ_OPERATOR,    4'd0,      OP_REM,  1'b0, ZERO_QUIET},
    '{REQ_EQUALS,      4'd0,      OP_NONE, 1'b0, ZERO_QUIET},
    '{REQ_BAD_LO,      4'd0,      OP_NONE, 1'b0, ZERO_QUIET},
    '{REQ_BAD_HI,      4'd0,      OP_NONE, 1'b0, ZERO_QUIET},
    '{REQ_CLEAR_ENTRY, 4'd0,      OP_NONE, 1'b0, ZERO_QUIET},
    '{REQ_ALL_CLEAR,   4'd0,      OP_NONE, 1'b1, ZERO_BLANK}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  kic_key_if    key_ch ();
  kic_result_if res_ch ();

  keypad_integer_calculator_top #(.DATA_WIDTH(DW)) u_top (
    .clk    (clk),
    .rst    (rst),
    .key    (key_ch),
    .result (res_ch)
  );

  // calculator state as the predictor sees it
  logic [DW-1:0] entry_a;
  logic [DW-1:0] entry_b;
  logic [DW-1:0] shown_res;
  op_t           op_pend;
  logic          op_seen;

  readout_t readout_q [$];
  int       err_cnt   = 0;
  int       key_cnt   = 0;
  int       cycle_cnt = 0;
  int       src_idle_pct = 0;
  int       snk_idle_pct = 0;
  bit       hold_req = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  // signed divide, truncating toward zero; remainder follows the dividend
  function automatic logic [DW-1:0] quot_or_rem(input logic [DW-1:0] a, input logic [DW-1:0] b,
                                                input bit want_rem);
    logic [DW:0] mag_a, mag_b, q, m;
    mag_a = a[DW-1] ? ({1'b1, {DW{1'b0}}} - {1'b0, a}) : {1'b0, a};
    mag_b = b[DW-1] ? ({1'b1, {DW{1'b0}}} - {1'b0, b}) : {1'b0, b};
    q = mag_a / mag_b;
    m = mag_a % mag_b;
    if (want_rem) return a[DW-1] ? DW'(-m) : m[DW-1:0];
    return (a[DW-1] ^ b[DW-1]) ? DW'(-q) : q[DW-1:0];
  endfunction

  function automatic readout_t press_key(input logic [REQ_W-1:0] rq,
                                         input logic [DIGIT_W-1:0] dg,
                                         input logic [OPC_W-1:0] oc);
    readout_t r;
    r.act = ACT_NONE;
    r.err = 1'b0;
    case (rq)
      REQ_DIGIT: begin
        if (dg <= DIGIT_MAX) begin
          if (op_seen) entry_b = entry_b * DW'(DECIMAL_BASE) + DW'(dg);
          else entry_a = entry_a * DW'(DECIMAL_BASE) + DW'(dg);
        end
      end
      REQ_OPERATOR: begin
        if (oc >= OP_ADD && oc <= OP_REM) begin
          op_pend = op_t'(oc);
          op_seen = 1'b1;
        end
      end
      REQ_EQUALS: begin
        case (op_pend)
          OP_ADD: shown_res = entry_a + entry_b;
          OP_SUB: shown_res = entry_a - entry_b;
          OP_MUL: shown_res = entry_a * entry_b;
          OP_DIV, OP_REM: begin
            if (entry_b == '0) r.err = 1'b1;
            else shown_res = quot_or_rem(entry_a, entry_b, op_pend == OP_REM);
          end
          default: ;
        endcase
        r.act = ACT_SHOW;
      end
      REQ_CLEAR_ENTRY: begin
        entry_a = '0;
        entry_b = '0;
        op_pend = OP_NONE;
        op_seen = 1'b0;
        r.act   = ACT_SHOW;
      end
      REQ_ALL_CLEAR: begin
        entry_a   = '0;
        entry_b   = '0;
        shown_res = '0;
        op_pend   = OP_NONE;
        op_seen   = 1'b0;
        r.act     = ACT_BLANK;
      end
      default: ;
    endcase
    r.value = VALUE_W'($signed(shown_res));
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_key(input logic [REQ_W-1:0] rq, input logic [DIGIT_W-1:0] dg,
                          input logic [OPC_W-1:0] oc, input bit fixed, input readout_t fixed_r);
    readout_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      key_ch.valid <= 1'b0;
      @(negedge clk);
    end
    key_ch.valid         <= 1'b1;
    key_ch.req_type      <= rq;
    key_ch.digit         <= dg;
    key_ch.operator_code <= oc;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    pred = press_key(rq, dg, oc);
    readout_q.push_back(fixed ? fixed_r : pred);
    key_cnt++;
    @(negedge clk);
  endtask

  task automatic tap(input logic [REQ_W-1:0] rq, input logic [DIGIT_W-1:0] dg,
                     input logic [OPC_W-1:0] oc);
    send_key(rq, dg, oc, 1'b0, ZERO_QUIET);
  endtask

  function automatic logic [DIGIT_W-1:0] junk_digit();
    return DIGIT_W'($urandom_range(15));
  endfunction

  function automatic logic [OPC_W-1:0] junk_opc();
    return OPC_W'($urandom_range(7));
  endfunction

  task automatic enter_number(input longint unsigned n);
    logic [DIGIT_W-1:0] digs [$];
    do begin
      digs.push_front(DIGIT_W'(n % DECIMAL_BASE));
      n = n / DECIMAL_BASE;
    end while (n != 0);
    foreach (digs[i]) tap(REQ_DIGIT, digs[i], junk_opc());
  endtask

  // mostly short numbers; now and then an extreme, a long wrapping one, or no digits at all
  task automatic enter_operand();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    if (pick < 6) enter_number(MIN_DEC);
    else if (pick < 12) enter_number(NEG_ONE_DEC);
    else if (pick < 17) enter_number(MAX_DEC);
    else if (pick < 22) enter_number(0);
    else if (pick >= 30) begin
      len = (pick < 90) ? $urandom_range(4, 1) : $urandom_range(12, 5);
      repeat (len) begin
        if ($urandom_range(19) == 0) tap(REQ_DIGIT, DIGIT_W'($urandom_range(15, 10)), junk_opc());
        else tap(REQ_DIGIT, DIGIT_W'($urandom_range(9)), junk_opc());
      end
    end
  endtask

  task automatic run_noise();
    tap(REQ_W'($urandom_range(7)), junk_digit(), junk_opc());
  endtask

  task automatic run_sequence();
    int unsigned style;
    bit corner;
    style  = $urandom_range(99);
    corner = ($urandom_range(15) == 0);
    if (corner || style < 45) begin
      if ($urandom_range(1)) tap(REQ_ALL_CLEAR, junk_digit(), junk_opc());
      else tap(REQ_CLEAR_ENTRY, junk_digit(), junk_opc());
    end
    // without a clear the digits extend whatever operand the last sequence left
    if (corner) enter_number(MIN_DEC);
    else if (style < 80) enter_operand();
    if (corner) tap(REQ_OPERATOR, junk_digit(), $urandom_range(1) ? OP_DIV : OP_REM);
    else tap(REQ_OPERATOR, junk_digit(), OPC_W'($urandom_range(OP_REM, OP_ADD)));
    if ($urandom_range(99) < 15) tap(REQ_OPERATOR, junk_digit(), OPC_W'($urandom_range(OP_REM, OP_ADD)));
    if ($urandom_range(9) == 0) run_noise();
    if (corner) enter_number(NEG_ONE_DEC);
    else enter_operand();
    repeat ($urandom_range(3, 1)) tap(REQ_EQUALS, junk_digit(), junk_opc());
  endtask

  // sender pause: wait for every pending result, then for the block to go quiet
  task automatic wait_drained();
    key_ch.valid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_results
    readout_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (readout_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result, value %0d", res_ch.value));
      end else begin
        want = readout_q.pop_front();
        if (res_ch.value !== want.value)
          report_mismatch($sformatf("value %0d, want %0d", res_ch.value, want.value));
        if (res_ch.display_action !== want.act)
          report_mismatch($sformatf("display_action %0d, want %0d",
                                    res_ch.display_action, want.act));
        if (res_ch.divide_error !== want.err)
          report_mismatch($sformatf("divide_error %0b, want %0b",
                                    res_ch.divide_error, want.err));
      end
    end
  end

  initial begin : result_sink
    int hold_left;
    hold_left    = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && hold_left == 0) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    key_ch.valid         = 1'b0;
    key_ch.req_type      = REQ_DIGIT;
    key_ch.digit         = '0;
    key_ch.operator_code = OP_NONE;
    entry_a   = '0;
    entry_b   = '0;
    shown_res = '0;
    op_pend   = OP_NONE;
    op_seen   = 1'b0;
    src_idle_pct = 18;
    snk_idle_pct = 49;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (intro_keys[i])
      send_key(intro_keys[i].req, intro_keys[i].dig, intro_keys[i].opc,
               intro_keys[i].fixed, intro_keys[i].want);
    wait_drained();

    for (int ph = 0; ph < 3; ph++) begin
      src_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 49 : 0;
      snk_idle_pct = (ph == 0) ? 49 : (ph == 1) ? 18 : 0;
      // long receiver hold while keys keep coming, so the input backs up
      if (ph != 1) begin
        hold_req = 1'b1;
        repeat (4) run_sequence();
      end
      while (key_cnt < N_INTRO + (ph + 1) * PHASE_KEYS) begin
        if ($urandom_range(99) < 80) run_sequence();
        else repeat ($urandom_range(4, 1)) run_noise();
      end
      wait_drained();
    end

    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
